### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/pata_pkg.sv
// shared types, codes and helpers for the parent array tree ancestor block
package pata_pkg;

    localparam int unsigned NODES_DEF = 64;
    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned NODE_W    = 7;
    localparam int unsigned IN_W      = 16;
    localparam int unsigned OUT_W     = 8;

    typedef logic [FUNC_W-1:0] func_t;
    typedef logic signed [NODE_W-1:0] node_t;

    localparam func_t FUNC_SET_PARENT = 2'd0;
    localparam func_t FUNC_DETACH     = 2'd1;
    localparam func_t FUNC_ANCESTOR   = 2'd2;
    localparam func_t FUNC_TRACE      = 2'd3;

    localparam node_t NODE_NONE = '1;

    typedef logic [1:0] src_t;

    localparam src_t SRC_NONE = 2'd0;
    localparam src_t SRC_A    = 2'd1;
    localparam src_t SRC_CUR  = 2'd2;

    typedef struct packed {
        logic wr_table;
        logic clr_marks;
        logic set_mark;
        logic load_a;
        logic load_b;
        logic advance;
        logic emit;
        src_t out_src;
        logic out_last;
        logic out_err;
    } dp_cmd_t;

    typedef struct packed {
        func_t func;
        logic  a_ok;
        logic  b_ok;
        logic  same;
        logic  nxt_ok;
        logic  last_step;
        logic  hit;
        logic  out_vld;
        logic  out_free;
    } dp_sts_t;

    function automatic logic node_ok(node_t n, int unsigned nodes);
        logic [31:0] ext;
        ext = 32'(unsigned'(n));
        return !n[NODE_W-1] && (ext < nodes);
    endfunction

endpackage

### rtl/pata_dpath.sv
// datapath: parent table memory, walk registers, ancestor marks and result register
module pata_dpath #(
    parameter int unsigned NODES = pata_pkg::NODES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [pata_pkg::IN_W-1:0]  s_tdata,
    output logic [pata_pkg::OUT_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  pata_pkg::dp_cmd_t          cmd,
    output pata_pkg::dp_sts_t          sts
);
    import pata_pkg::*;

    localparam int unsigned IDX_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int unsigned CNT_W = $clog2(NODES + 1);

    func_t in_func;
    node_t in_a;
    node_t in_b;
    node_t nxt;
    node_t wr_data;

    logic [NODE_W-1:0] tbl_mem [NODES];
    logic [IDX_W-1:0]  rd_addr;
    logic [IDX_W-1:0]  cur_idx;

    node_t            cur_reg, cur_next;
    node_t            b_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NODES-1:0] mark_reg, mark_next;
    logic [NODES-1:0] tbl_vld_reg, tbl_vld_next;
    node_t            rd_reg;
    logic             rd_vld_reg;
    node_t            out_node_reg, out_node_next;
    logic             out_last_reg;
    logic             out_err_reg;
    logic             out_vld_reg, out_vld_next;

    assign in_func = s_tdata[FUNC_W-1:0];
    assign in_a    = s_tdata[FUNC_W+NODE_W-1:FUNC_W];
    assign in_b    = s_tdata[FUNC_W+2*NODE_W-1:FUNC_W+NODE_W];
    assign cur_idx = cur_reg[IDX_W-1:0];
    assign nxt     = rd_vld_reg ? rd_reg : NODE_NONE;
    assign wr_data = (in_func == FUNC_SET_PARENT && node_ok(in_b, NODES)) ? in_b : NODE_NONE;

    always_comb
    begin
        rd_addr  = cur_idx;
        cur_next = cur_reg;
        cnt_next = cnt_reg;
        priority if (cmd.load_a)
        begin
            rd_addr  = in_a[IDX_W-1:0];
            cur_next = in_a;
            cnt_next = '0;
        end
        else if (cmd.load_b)
        begin
            rd_addr  = b_reg[IDX_W-1:0];
            cur_next = b_reg;
            cnt_next = '0;
        end
        else if (cmd.advance)
        begin
            rd_addr  = nxt[IDX_W-1:0];
            cur_next = nxt;
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        mark_next = mark_reg;
        if (cmd.clr_marks)
        begin
            mark_next = '0;
        end
        else if (cmd.set_mark)
        begin
            mark_next[cur_idx] = 1'b1;
        end
    end

    always_comb
    begin
        tbl_vld_next = tbl_vld_reg;
        if (cmd.wr_table)
        begin
            tbl_vld_next[in_a[IDX_W-1:0]] = 1'b1;
        end
    end

    always_comb
    begin
        unique case (cmd.out_src)
            SRC_A:   out_node_next = in_a;
            SRC_CUR: out_node_next = cur_reg;
            default: out_node_next = NODE_NONE;
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.emit)
        begin
            out_vld_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    // parent table storage
    always_ff @(posedge clk)
    begin
        if (cmd.wr_table)
        begin
            tbl_mem[in_a[IDX_W-1:0]] <= wr_data;
        end
        rd_reg <= tbl_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.load_a)
        begin
            b_reg <= in_b;
        end
        if (cmd.emit)
        begin
            out_node_reg <= out_node_next;
            out_last_reg <= cmd.out_last;
            out_err_reg  <= cmd.out_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            mark_reg    <= '0;
            tbl_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            cnt_reg     <= cnt_next;
            mark_reg    <= mark_next;
            tbl_vld_reg <= tbl_vld_next;
            rd_vld_reg  <= tbl_vld_reg[rd_addr];
            out_vld_reg <= out_vld_next;
        end
    end

    assign m_tdata  = {{(OUT_W-NODE_W){1'b0}}, out_node_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;
    assign m_tvalid = out_vld_reg;

    assign sts.func      = in_func;
    assign sts.a_ok      = node_ok(in_a, NODES);
    assign sts.b_ok      = node_ok(in_b, NODES);
    assign sts.same      = (in_a == in_b);
    assign sts.nxt_ok    = node_ok(nxt, NODES);
    assign sts.last_step = (cnt_reg == CNT_W'(NODES - 1));
    assign sts.hit       = mark_reg[cur_idx];
    assign sts.out_vld   = out_vld_reg;
    assign sts.out_free  = !out_vld_reg || m_tready;

endmodule

### rtl/pata_ctrl.sv
// controller: command decode and walk sequencing
module pata_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  pata_pkg::dp_sts_t sts,
    output pata_pkg::dp_cmd_t cmd
);
    import pata_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_MARK   = 2'd1;
    localparam logic [1:0] ST_SEARCH = 2'd2;
    localparam logic [1:0] ST_TRACE  = 2'd3;

    logic [1:0] state_reg, state_next;

    assign s_tready = (state_reg == ST_IDLE) && !sts.out_vld;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd.out_last = 1'b1;
                    cmd.out_src  = SRC_NONE;
                    unique case (sts.func)
                        FUNC_SET_PARENT, FUNC_DETACH:
                        begin
                            cmd.wr_table = sts.a_ok;
                            cmd.emit     = 1'b1;
                        end
                        FUNC_ANCESTOR:
                        begin
                            priority if (!(sts.a_ok && sts.b_ok))
                            begin
                                cmd.emit = 1'b1;
                            end
                            else if (sts.same)
                            begin
                                cmd.emit    = 1'b1;
                                cmd.out_src = SRC_A;
                            end
                            else
                            begin
                                cmd.clr_marks = 1'b1;
                                cmd.load_a    = 1'b1;
                                state_next    = ST_MARK;
                            end
                        end
                        default:
                        begin
                            if (!sts.a_ok)
                            begin
                                cmd.emit = 1'b1;
                            end
                            else
                            begin
                                cmd.load_a = 1'b1;
                                state_next = ST_TRACE;
                            end
                        end
                    endcase
                end
            end
            ST_MARK:
            begin
                cmd.set_mark = 1'b1;
                priority if (sts.nxt_ok && !sts.last_step)
                begin
                    cmd.advance = 1'b1;
                end
                else if (sts.nxt_ok)
                begin
                    // first walk ran out of steps: loop
                    cmd.emit     = 1'b1;
                    cmd.out_src  = SRC_NONE;
                    cmd.out_last = 1'b1;
                    cmd.out_err  = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.load_b = 1'b1;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                priority if (sts.hit)
                begin
                    cmd.emit     = 1'b1;
                    cmd.out_src  = SRC_CUR;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (sts.nxt_ok && !sts.last_step)
                begin
                    cmd.advance = 1'b1;
                end
                else
                begin
                    cmd.emit     = 1'b1;
                    cmd.out_src  = SRC_NONE;
                    cmd.out_last = 1'b1;
                    cmd.out_err  = sts.nxt_ok;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                if (sts.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.out_src = SRC_CUR;
                    if (sts.nxt_ok && !sts.last_step)
                    begin
                        cmd.advance = 1'b1;
                    end
                    else
                    begin
                        cmd.out_last = 1'b1;
                        cmd.out_err  = sts.nxt_ok;
                        state_next   = ST_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### rtl/parent_array_tree_ancestor_top.sv
// Parent-pointer forest over NODES nodes with lowest-common-ancestor and
// ancestor-trace queries. One transaction is taken at a time, only when the
// block is idle and its result register is empty. set_parent and detach
// finish in the accept cycle and show their acknowledge the next cycle.
// common_ancestor walks the parent table one link per cycle, first marking
// the first node's ancestors, then walking up from the second node. trace_back
// gives one result per cycle while the sink takes them, up to NODES results.
// The walk rate is set by the parent table's registered read.
module parent_array_tree_ancestor_top #(
    parameter int unsigned NODES = pata_pkg::NODES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [pata_pkg::IN_W-1:0]  s_tdata,   // func, node_a, node_b
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [pata_pkg::OUT_W-1:0] m_tdata,   // result_node, zero pad
    output logic                       m_tlast,
    output logic                       m_tuser    // walk_error
);
    import pata_pkg::*;

    `include "assert_macros.svh"

    dp_cmd_t cmd;
    dp_sts_t sts;
    logic    wr_accept;

    pata_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pata_dpath #(
        .NODES (NODES)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    assign wr_accept = s_tvalid && s_tready &&
                       (s_tdata[FUNC_W-1:0] == FUNC_SET_PARENT ||
                        s_tdata[FUNC_W-1:0] == FUNC_DETACH);

    `ASSERT_IMPLIES(a_rdy_out_empty, s_tready, !m_tvalid)
    `ASSERT_NEXT(a_wr_ack, wr_accept, m_tvalid && m_tlast && !m_tuser && m_tdata[NODE_W-1:0] == NODE_NONE)
    `ASSERT_IMPLIES(a_err_last, m_tvalid && m_tuser, m_tlast)
    `ASSERT_IMPLIES(a_walk_no_emit, cmd.load_a || cmd.load_b || cmd.set_mark, !cmd.emit || !cmd.load_a)

endmodule
